### src/sha1_stream_hasher_top_assert.svh
// Assertion macros for the SHA-1 stream hasher checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SHA1_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA1_STREAM_HASHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SHA1SH_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sha1sh checker: same-cycle implication failed");

// Next-cycle implication, disabled while reset is held.
`define SHA1SH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sha1sh checker: next-cycle implication failed");

`endif

### src/sha1sh_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and round functions of the SHA-1 stream hasher.
// No dependencies; the front, queue, engine, top level and checker use it.
package sha1sh_pkg;

  // Command queue between the front and the compression engine.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Block and chain geometry.
  localparam int unsigned BlockWords = 16;
  localparam int unsigned BlockIdxW  = $clog2(BlockWords);
  localparam int unsigned LenHiIdx   = 14;
  localparam int unsigned ChainWords = 5;
  localparam int unsigned ChainIdxW  = $clog2(ChainWords);
  localparam int unsigned Rounds     = 80;
  localparam int unsigned RoundW     = $clog2(Rounds);

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] KRound0 = 32'h5A827999;
  localparam logic [31:0] KRound1 = 32'h6ED9EBA1;
  localparam logic [31:0] KRound2 = 32'h8F1BBCDC;
  localparam logic [31:0] KRound3 = 32'hCA62C1D6;

  localparam logic [31:0] HInit [ChainWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Word-level commands from the front to the engine.
  typedef enum logic [1:0] {
    OP_WORD,   // message or length word, appended to the block
    OP_PAD,    // word holding the 0x80 marker; zero fill follows up to the length
    OP_FINAL   // low length word; closes the message and releases the digest
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] word;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  // Round logic function by round number.
  function automatic logic [31:0] round_f(input logic [RoundW-1:0] rnd,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] f;
    case (rnd) inside
      [RoundW'(0):RoundW'(19)]:  f = (b & c) | (~b & d);
      [RoundW'(40):RoundW'(59)]: f = (b & c) | (b & d) | (c & d);
      default:                   f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  // Round constant by round number.
  function automatic logic [31:0] round_k(input logic [RoundW-1:0] rnd);
    logic [31:0] k;
    case (rnd) inside
      [RoundW'(0):RoundW'(19)]:  k = KRound0;
      [RoundW'(20):RoundW'(39)]: k = KRound1;
      [RoundW'(40):RoundW'(59)]: k = KRound2;
      default:                   k = KRound3;
    endcase
    return k;
  endfunction

endpackage

### src/sha1sh_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the SHA-1 stream hasher.
// Input items carry a byte and flags; output items carry digest words.
interface sha1sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, data_byte, has_byte, last, input ready);
  modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha1sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        word_last;

  modport source (output valid, digest_word, word_last, input ready);
  modport sink   (input valid, digest_word, word_last, output ready);
endinterface

### src/sha1sh_front.sv
`timescale 1ns / 1ps
// Front of the SHA-1 stream hasher: packs bytes into words, counts the
// message length and issues padding commands. Uses sha1sh_pkg and sha1sh_if.
module sha1sh_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sha1sh_in_if.sink           in_i,
  output sha1sh_pkg::push_t   push_o,
  input  logic                push_ready_i
);

  typedef enum logic [1:0] {F_IDLE, F_PAD, F_HI, F_LO} state_e;

  state_e      state_q, state_d;
  logic [31:0] word_q, word_d;
  logic [1:0]  pos_q, pos_d;
  logic [63:0] bits_q, bits_d;
  logic        accept;

  // Place a byte at a big-endian position of a partial word.
  function automatic logic [31:0] put_byte(input logic [31:0] w,
                                           input logic [1:0]  pos,
                                           input logic [7:0]  data);
    logic [31:0] r;
    case (pos)
      2'd0:    r = {data, 24'h000000};
      2'd1:    r = {w[31:24], data, 16'h0000};
      2'd2:    r = {w[31:16], data, 8'h00};
      default: r = {w[31:8], data};
    endcase
    return r;
  endfunction

  // An item is taken only in idle with room for the word it may complete.
  assign in_i.ready = (state_q == F_IDLE) && push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // Next state, byte packing and command issue.
  always_comb begin
    state_d            = state_q;
    word_d             = word_q;
    pos_d              = pos_q;
    bits_d             = bits_q;
    push_o.valid       = 1'b0;
    push_o.cmd.op      = sha1sh_pkg::OP_WORD;
    push_o.cmd.word    = put_byte(word_q, pos_q, in_i.data_byte);
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (in_i.has_byte) begin
            word_d = put_byte(word_q, pos_q, in_i.data_byte);
            pos_d  = pos_q + 2'd1;
            bits_d = bits_q + 64'd8;
            push_o.valid = (pos_q == 2'd3);
          end
          if (in_i.last) begin
            state_d = F_PAD;
          end
        end
      end
      F_PAD: begin
        push_o.valid    = 1'b1;
        push_o.cmd.op   = sha1sh_pkg::OP_PAD;
        push_o.cmd.word = put_byte(word_q, pos_q, sha1sh_pkg::PadByte);
        if (push_ready_i) begin
          state_d = F_HI;
        end
      end
      F_HI: begin
        push_o.valid    = 1'b1;
        push_o.cmd.op   = sha1sh_pkg::OP_WORD;
        push_o.cmd.word = bits_q[63:32];
        if (push_ready_i) begin
          state_d = F_LO;
        end
      end
      F_LO: begin
        push_o.valid    = 1'b1;
        push_o.cmd.op   = sha1sh_pkg::OP_FINAL;
        push_o.cmd.word = bits_q[31:0];
        if (push_ready_i) begin
          state_d = F_IDLE;
          pos_d   = 2'd0;
          bits_d  = 64'd0;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  // Control state and length counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      pos_q   <= 2'd0;
      bits_q  <= 64'd0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      bits_q  <= bits_d;
    end
  end

  // Partial word under assembly; each word starts fresh at its first byte.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

### src/sha1sh_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front and the compression engine.
// Uses sha1sh_pkg for the command type and depth.
module sha1sh_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha1sh_pkg::push_t   push_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output sha1sh_pkg::cmd_t    pop_cmd_o,
  input  logic                pop_ready_i
);

  sha1sh_pkg::cmd_t                      mem_q [sha1sh_pkg::QueueDepth];
  logic [sha1sh_pkg::QueuePtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [sha1sh_pkg::QueueCntW-1:0]      count_q;
  logic                                  do_push, do_pop;

  assign push_ready_o = (count_q != sha1sh_pkg::QueueCntW'(sha1sh_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer step with wrap at the queue depth.
  function automatic logic [sha1sh_pkg::QueuePtrW-1:0] ptr_next(
      input logic [sha1sh_pkg::QueuePtrW-1:0] p);
    logic [sha1sh_pkg::QueuePtrW-1:0] r;
    if (p == sha1sh_pkg::QueuePtrW'(sha1sh_pkg::QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

### src/sha1sh_core.sv
`timescale 1ns / 1ps
// Compression engine of the SHA-1 stream hasher: block window, zero fill,
// one round per cycle, chain update and digest output. Uses sha1sh_pkg, sha1sh_if.
module sha1sh_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  input  sha1sh_pkg::cmd_t   pop_cmd_i,
  output logic               pop_ready_o,
  sha1sh_out_if.source       out_o
);

  typedef enum logic [2:0] {C_LOAD, C_ZERO, C_ROUND, C_ADD, C_OUT} state_e;

  localparam int unsigned NW = sha1sh_pkg::BlockWords;
  localparam int unsigned NH = sha1sh_pkg::ChainWords;

  state_e                              state_q;
  logic [sha1sh_pkg::BlockIdxW-1:0]    cnt_q;
  logic [sha1sh_pkg::RoundW-1:0]       rnd_q;
  logic [sha1sh_pkg::ChainIdxW-1:0]    idx_q;
  logic                                zfill_q, final_q;
  logic [31:0]                         h_q [NH];
  logic [31:0]                         w_q [NW];
  logic [31:0]                         a_q, b_q, c_q, d_q, e_q;
  logic                                out_valid_q, out_last_q;
  logic [31:0]                         out_word_q;

  logic                                pop;
  logic                                shift_en;
  logic [31:0]                         shift_word;
  logic [31:0]                         sched, tmp;
  logic                                blk_end, at_len;

  assign pop_ready_o = (state_q == C_LOAD);
  assign pop         = pop_valid_i && pop_ready_o;
  assign blk_end     = (cnt_q == sha1sh_pkg::BlockIdxW'(NW - 1));
  assign at_len      = (cnt_q == sha1sh_pkg::BlockIdxW'(sha1sh_pkg::LenHiIdx));

  assign out_o.valid       = out_valid_q;
  assign out_o.digest_word = out_word_q;
  assign out_o.word_last   = out_last_q;

  // Message schedule and round sum; w_q[0] is the current schedule word.
  assign sched = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign tmp   = {a_q[26:0], a_q[31:27]}
               + sha1sh_pkg::round_f(rnd_q, b_q, c_q, d_q)
               + e_q + sha1sh_pkg::round_k(rnd_q) + w_q[0];

  // Word entering the block window this cycle.
  always_comb begin
    shift_en   = 1'b0;
    shift_word = pop_cmd_i.word;
    case (state_q)
      C_LOAD: begin
        shift_en = pop;
      end
      C_ZERO: begin
        shift_en   = !at_len;
        shift_word = 32'h0;
      end
      C_ROUND: begin
        shift_en   = 1'b1;
        shift_word = {sched[30:0], sched[31]};
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
  end

  // Block window and working variables.
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < NW - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[NW-1] <= shift_word;
    end
    if (state_q == C_ROUND) begin
      a_q <= tmp;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end else begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end
  end

  // Sequencer, chain value and registered output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_LOAD;
      cnt_q       <= '0;
      rnd_q       <= '0;
      idx_q       <= '0;
      zfill_q     <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_word_q  <= 32'h0;
      for (int i = 0; i < NH; i++) begin
        h_q[i] <= sha1sh_pkg::HInit[i];
      end
    end else begin
      // A taken output item is dropped here; the digest state refills it itself.
      if (out_o.ready && (state_q != C_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        C_LOAD: begin
          if (pop) begin
            cnt_q <= cnt_q + 1'b1;
            if (blk_end) begin
              state_q <= C_ROUND;
              rnd_q   <= '0;
              final_q <= (pop_cmd_i.op == sha1sh_pkg::OP_FINAL);
              zfill_q <= (pop_cmd_i.op == sha1sh_pkg::OP_PAD);
            end else if (pop_cmd_i.op == sha1sh_pkg::OP_PAD) begin
              state_q <= C_ZERO;
            end
          end
        end
        C_ZERO: begin
          // Zero words up to the length field, compressing on a full block.
          if (at_len) begin
            state_q <= C_LOAD;
            zfill_q <= 1'b0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            if (blk_end) begin
              state_q <= C_ROUND;
              rnd_q   <= '0;
              zfill_q <= 1'b1;
            end
          end
        end
        C_ROUND: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == sha1sh_pkg::RoundW'(sha1sh_pkg::Rounds - 1)) begin
            state_q <= C_ADD;
          end
        end
        C_ADD: begin
          h_q[0] <= h_q[0] + a_q;
          h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q;
          h_q[4] <= h_q[4] + e_q;
          if (final_q) begin
            state_q <= C_OUT;
            idx_q   <= '0;
          end else if (zfill_q) begin
            state_q <= C_ZERO;
          end else begin
            state_q <= C_LOAD;
          end
        end
        C_OUT: begin
          // Hand out H0..H4, then restore the initial chain value.
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_word_q  <= h_q[idx_q];
            out_last_q  <= (idx_q == sha1sh_pkg::ChainIdxW'(NH - 1));
            idx_q       <= idx_q + 1'b1;
            if (idx_q == sha1sh_pkg::ChainIdxW'(NH - 1)) begin
              state_q <= C_LOAD;
              final_q <= 1'b0;
              for (int i = 0; i < NH; i++) begin
                h_q[i] <= sha1sh_pkg::HInit[i];
              end
            end
          end
        end
        default: begin
          state_q <= C_LOAD;
        end
      endcase
    end
  end

endmodule

### src/sha1_stream_hasher_top.sv
`timescale 1ns / 1ps
// SHA-1 stream hasher, top level: front, command queue and compression engine.
// Uses sha1sh_pkg, sha1sh_if, sha1sh_front, sha1sh_fifo and sha1sh_core.

// The block hashes a byte stream with SHA-1 and returns H0..H4 as five output
// items after each item marked last. Input items are taken at one per cycle while
// the front is not padding and the four-entry command queue has room; every fourth
// byte becomes one queue entry. Compressing a block runs 80 rounds on one round unit
// and then one chain add. During that time the front runs ahead by only 16 bytes
// before the queue fills, and the remaining 48 bytes of the next block come in at one
// per cycle after it. Closing a message takes three queue entries, zero fill of the
// block up to its length words at one word per cycle, one or two compressions, and
// then five output items, handed out as the sink takes them. Items with neither a
// byte nor last are taken and have no effect.
module sha1_stream_hasher_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha1sh_in_if.sink    in_i,
  sha1sh_out_if.source out_o
);

  sha1sh_pkg::push_t push;
  logic              push_ready;
  logic              pop_valid;
  logic              pop_ready;
  sha1sh_pkg::cmd_t  pop_cmd;

  // Byte packing, length count and padding commands.
  sha1sh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  // Decoupling queue.
  sha1sh_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  // Compression and digest output.
  sha1sh_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

### src/sha1sh_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the SHA-1 stream hasher and its bind to the top level.
// Uses sha1sh_pkg and the macros of sha1_stream_hasher_top_assert.svh.
`include "sha1_stream_hasher_top_assert.svh"

module sha1sh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_digest_word_i,
  input logic        out_word_last_i
);

  localparam logic [2:0] LastWordIdx = 3'(sha1sh_pkg::ChainWords - 1);

  logic [2:0] word_cnt_q;
  logic [3:0] pend_q;
  logic       in_end, out_end, out_acc;

  assign in_end  = in_valid_i && in_ready_i && in_last_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign out_end = out_acc && out_word_last_i;

  // Digest word position and count of messages closed but not yet output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_cnt_q <= '0;
      pend_q     <= '0;
    end else begin
      if (out_acc) begin
        word_cnt_q <= (word_cnt_q == LastWordIdx) ? 3'd0 : word_cnt_q + 3'd1;
      end
      if (in_end && !out_end) begin
        pend_q <= pend_q + 4'd1;
      end else if (out_end && !in_end) begin
        pend_q <= pend_q - 4'd1;
      end
    end
  end

  `SHA1SH_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_digest_word_i) && $stable(out_word_last_i))
  `SHA1SH_ASSERT_IMPL(a_word_pos, out_valid_i, out_word_last_i == (word_cnt_q == LastWordIdx))
  `SHA1SH_ASSERT_IMPL(a_no_stray_digest, out_valid_i, pend_q != 4'd0)
  `SHA1SH_ASSERT_NEXT(a_busy_after_end, in_end, !in_ready_i)

endmodule

bind sha1_stream_hasher_top sha1sh_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_last_i         (in_i.last),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_digest_word_i (out_o.digest_word),
  .out_word_last_i   (out_o.word_last)
);
